// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

   localparam logic [3:0]  OP_TEXT   = 4'h1;
   localparam logic [3:0]  OP_BINARY = 4'h2;
   localparam logic [3:0]  OP_CLOSE  = 4'h8;

   localparam logic        KIND_DATA  = 1'b0;
   localparam logic        KIND_CLOSE = 1'b1;

   localparam logic [6:0]  LEN_EXT16 = 7'd126;
   localparam logic [6:0]  LEN_EXT64 = 7'd127;

   localparam logic [15:0] MAX_CHUNK_RESET = 16'd1024;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic       is_text;
      logic       chunk_last;
   } rsp_item_type;

endpackage

// ===== hdl/wsd_parser.sv =====
module wsd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   output logic                  res_valid,
   output wsd_pkg::rsp_item_type res
);

   localparam logic [2:0] PH_HDR1    = 3'd0;
   localparam logic [2:0] PH_HDR2    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [15:0] max_chunk_ff, max_chunk_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_on_ff, mask_on_in;
   logic [63:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  field_ff, field_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic [15:0] chunk_count_ff, chunk_count_in;
   logic        closed_ff, closed_in;

   logic [6:0]  len7;
   logic [2:0]  field_dec;
   logic        len_done;
   logic        start_payload;
   logic [15:0] limit;
   logic [16:0] count_inc;
   logic [63:0] left_dec;
   logic        chunk_end;
   logic [7:0]  key_byte;

   assign len7      = rx_byte[6:0];
   assign field_dec = field_ff - 3'd1;
   assign limit     = (max_chunk_ff == 16'd0) ? 16'd1 : max_chunk_ff;
   assign count_inc = {1'b0, chunk_count_ff} + 17'd1;
   assign left_dec  = bytes_left_ff - 64'd1;
   assign key_byte  = mask_key_ff[{~mask_pos_ff, 3'b000} +: 8];
   assign chunk_end = (left_dec == 64'd0) || (count_inc >= {1'b0, limit});

   always_comb begin
      max_chunk_in   = csr_we ? csr_wdata : max_chunk_ff;
      phase_in       = phase_ff;
      opcode_in      = opcode_ff;
      mask_on_in     = mask_on_ff;
      bytes_left_in  = bytes_left_ff;
      field_in       = field_ff;
      mask_key_in    = mask_key_ff;
      mask_pos_in    = mask_pos_ff;
      chunk_count_in = chunk_count_ff;
      closed_in      = closed_ff;
      len_done       = 1'b0;
      start_payload  = 1'b0;
      res_valid      = 1'b0;
      res            = '0;

      if (accept && !closed_ff) begin
         case (phase_ff)
            PH_HDR1: begin
               opcode_in     = rx_byte[3:0];
               mask_on_in    = 1'b0;
               bytes_left_in = 64'd0;
               phase_in      = PH_HDR2;
            end
            PH_HDR2: begin
               mask_on_in = rx_byte[7];
               if (len7 < wsd_pkg::LEN_EXT16) begin
                  bytes_left_in = {57'd0, len7};
                  len_done      = 1'b1;
               end else begin
                  bytes_left_in = 64'd0;
                  // eight length bytes: 3-bit count wraps from zero
                  field_in      = (len7 == wsd_pkg::LEN_EXT64) ? 3'd0 : 3'd2;
                  phase_in      = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               bytes_left_in = {bytes_left_ff[55:0], rx_byte};
               field_in      = field_dec;
               len_done      = (field_dec == 3'd0);
            end
            PH_KEY: begin
               mask_key_in   = {mask_key_ff[23:0], rx_byte};
               field_in      = field_dec;
               start_payload = (field_dec == 3'd0);
            end
            PH_PAYLOAD: begin
               mask_pos_in    = mask_pos_ff + 2'd1;
               bytes_left_in  = left_dec;
               chunk_count_in = chunk_end ? 16'd0 : count_inc[15:0];
               if (left_dec == 64'd0) begin
                  phase_in = PH_HDR1;
               end
               if (opcode_ff == wsd_pkg::OP_TEXT || opcode_ff == wsd_pkg::OP_BINARY) begin
                  res_valid        = 1'b1;
                  res.kind         = wsd_pkg::KIND_DATA;
                  res.payload_byte = mask_on_ff ? (rx_byte ^ key_byte) : rx_byte;
                  res.is_text      = (opcode_ff == wsd_pkg::OP_TEXT);
                  res.chunk_last   = chunk_end;
               end else if (opcode_ff == wsd_pkg::OP_CLOSE && chunk_end) begin
                  res_valid = 1'b1;
                  res.kind  = wsd_pkg::KIND_CLOSE;
                  closed_in = 1'b1;
                  phase_in  = PH_HDR1;
               end
            end
            default: begin
               phase_in = PH_HDR1;
            end
         endcase

         if (len_done) begin
            if (mask_on_in) begin
               phase_in    = PH_KEY;
               field_in    = 3'd4;
               mask_key_in = 32'd0;
            end else begin
               start_payload = 1'b1;
            end
         end

         if (start_payload) begin
            mask_pos_in    = 2'd0;
            chunk_count_in = 16'd0;
            if (bytes_left_in == 64'd0) begin
               phase_in = PH_HDR1;
               if (opcode_ff == wsd_pkg::OP_CLOSE) begin
                  res_valid = 1'b1;
                  res.kind  = wsd_pkg::KIND_CLOSE;
                  closed_in = 1'b1;
               end
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunk_ff   <= wsd_pkg::MAX_CHUNK_RESET;
         phase_ff       <= PH_HDR1;
         opcode_ff      <= 4'd0;
         mask_on_ff     <= 1'b0;
         bytes_left_ff  <= 64'd0;
         field_ff       <= 3'd0;
         mask_pos_ff    <= 2'd0;
         chunk_count_ff <= 16'd0;
         closed_ff      <= 1'b0;
      end else begin
         max_chunk_ff   <= max_chunk_in;
         phase_ff       <= phase_in;
         opcode_ff      <= opcode_in;
         mask_on_ff     <= mask_on_in;
         bytes_left_ff  <= bytes_left_in;
         field_ff       <= field_in;
         mask_pos_ff    <= mask_pos_in;
         chunk_count_ff <= chunk_count_in;
         closed_ff      <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_key_ff <= mask_key_in;
   end

endmodule

// ===== hdl/wsd_out_buf.sv =====
module wsd_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wsd_pkg::rsp_item_type push_item,
   output logic                  has_room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output wsd_pkg::rsp_item_type out_item
);

   wsd_pkg::rsp_item_type head_ff, head_in;
   wsd_pkg::rsp_item_type skid_ff, skid_in;
   logic                  head_v_ff, head_v_in;
   logic                  skid_v_ff, skid_v_in;

   assign has_room  = !skid_v_ff;
   assign out_valid = head_v_ff;
   assign out_item  = head_ff;

   always_comb begin
      head_in   = head_ff;
      skid_in   = skid_ff;
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      if (!head_v_ff || out_ready) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            head_v_in = 1'b1;
            skid_in   = push_item;
            skid_v_in = push;
         end else begin
            head_in   = push_item;
            head_v_in = push;
         end
      end else if (push) begin
         skid_in   = push_item;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame receiver.
// req_*: one received byte per item, frames back to back (header, extended
//   length, masking key, payload). rsp_*: unmasked payload bytes of text and
//   binary frames, plus one close event when a close frame ends or fills its first chunk.
// csr_we/csr_wdata: payload bytes per chunk; write only while the block is idle.
// A result passes through the output buffer registers before it is shown on rsp_*.
// Throughput: one byte per cycle while req_tready is high; header, key and
//   discarded payload bytes are taken but produce no item.
// Results pass through a two-entry output buffer: req_tready drops only while
//   both entries hold items, so the input keeps flowing while the receiver stalls
//   until the second entry fills, and then waits; nothing is dropped.
// Reset (synchronous) empties the buffer, returns the parser to the first
//   header byte, clears the closed state and sets the chunk size to 1024.
// After a close event all further bytes are taken and ignored until reset.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // payload_byte
   output logic [1:0]  rsp_tuser,   // is_text, kind
   output logic        rsp_tlast,   // chunk_last
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic                  accept;
   logic                  res_valid;
   wsd_pkg::rsp_item_type res;
   wsd_pkg::rsp_item_type out_item;

   assign accept = req_tvalid && req_tready;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.payload_byte;
   assign rsp_tuser = {out_item.is_text, out_item.kind};
   assign rsp_tlast = out_item.chunk_last;

endmodule

// ===== hdl/wsd_checker.sv =====
`include "assert_macros.svh"

module wsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic close_shown;
   assign close_shown = rsp_tvalid && (rsp_tuser[0] == wsd_pkg::KIND_CLOSE);

   `ASSERT_IMPLY(a_close_clean, clock, reset, close_shown, rsp_tdata == 8'd0 && !rsp_tlast && !rsp_tuser[1], "close event carries data or flags")
   `ASSERT_NEXT(a_close_final, clock, reset, close_shown && rsp_tready, !rsp_tvalid, "item after close event")
   `ASSERT_IMPLY(a_reset_empty, clock, 1'b0, $past(reset), !rsp_tvalid && req_tready, "buffer not empty after reset")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled item changed")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/tb_websocket_frame_deframer.sv =====
module tb_websocket_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {P_HDR1, P_HDR2, P_EXTLEN, P_KEY, P_BODY} parse_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   websocket_frame_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // parser shadow
   logic [15:0]     chunk_cfg;
   parse_phase_type ph;
   logic [3:0]      frame_op;
   logic            masked;
   logic [63:0]     remaining;
   logic [3:0]      field_left;
   logic [31:0]     key;
   logic [1:0]      key_pos;
   logic [16:0]     chunk_cnt;
   logic            closed;

   wsd_pkg::rsp_item_type out_due[$];
   logic [7:0]   rx_bytes[$];
   int unsigned  bytes_queued = 0;
   int unsigned  bytes_taken = 0;
   int unsigned  error_count = 0;
   int unsigned  send_gap = 0;
   int unsigned  stall = 0;
   bit           calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_error(input string what);
      error_count++;
      $display("%0t: %s", $realtime, what);
   endtask

   task automatic note_close();
      out_due.push_back('{kind: wsd_pkg::KIND_CLOSE, payload_byte: 8'h00, is_text: 1'b0,
                          chunk_last: 1'b0});
      closed = 1'b1;
      ph = P_HDR1;
   endtask

   task automatic open_body();
      key_pos = '0;
      chunk_cnt = '0;
      if (remaining == 0) begin
         ph = P_HDR1;
         if (frame_op == wsd_pkg::OP_CLOSE) note_close();
      end else begin
         ph = P_BODY;
      end
   endtask

   task automatic length_done();
      if (masked) begin
         ph = P_KEY;
         field_left = 4'd4;
         key = '0;
      end else begin
         open_body();
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [16:0] limit;
      logic [7:0]  data;
      logic        fin;
      if (!closed) begin
         case (ph)
            P_HDR1: begin
               frame_op = b[3:0];
               masked = 1'b0;
               remaining = '0;
               key = '0;
               ph = P_HDR2;
            end
            P_HDR2: begin
               masked = b[7];
               remaining = '0;
               if (b[6:0] < wsd_pkg::LEN_EXT16) begin
                  remaining = 64'(b[6:0]);
                  length_done();
               end else begin
                  field_left = (b[6:0] == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
                  ph = P_EXTLEN;
               end
            end
            P_EXTLEN: begin
               remaining = {remaining[55:0], b};
               field_left--;
               if (field_left == 0) length_done();
            end
            P_KEY: begin
               key = {key[23:0], b};
               field_left--;
               if (field_left == 0) open_body();
            end
            P_BODY: begin
               limit = (chunk_cfg == 0) ? 17'd1 : 17'(chunk_cfg);
               data = masked ? (b ^ key[31 - 8 * key_pos -: 8]) : b;
               key_pos++;
               remaining--;
               chunk_cnt++;
               fin = (remaining == 0) || (chunk_cnt >= limit);
               if (fin) chunk_cnt = '0;
               if (remaining == 0) ph = P_HDR1;
               if (frame_op == wsd_pkg::OP_TEXT || frame_op == wsd_pkg::OP_BINARY) begin
                  out_due.push_back('{kind: wsd_pkg::KIND_DATA, payload_byte: data,
                                      is_text: (frame_op == wsd_pkg::OP_TEXT),
                                      chunk_last: fin});
               end else if (frame_op == wsd_pkg::OP_CLOSE && fin) begin
                  note_close();
               end
            end
            default: ph = P_HDR1;
         endcase
      end
   endtask

   task automatic put_byte(input logic [7:0] b);
      rx_bytes.push_back(b);
      bytes_queued++;
   endtask

   // form: 0 seven-bit length, 1 16-bit extended, 2 64-bit extended
   task automatic queue_frame(input logic [3:0] op, input logic mask, input logic [63:0] len,
                              input int form, input int unsigned send);
      put_byte({4'($urandom), op});
      if (form == 0) begin
         put_byte({mask, len[6:0]});
      end else if (form == 1) begin
         put_byte({mask, wsd_pkg::LEN_EXT16});
         put_byte(len[15:8]);
         put_byte(len[7:0]);
      end else begin
         put_byte({mask, wsd_pkg::LEN_EXT64});
         for (int i = 7; i >= 0; i--) put_byte(len[8 * i +: 8]);
      end
      if (mask) repeat (4) put_byte(8'($urandom));
      repeat (send) put_byte(8'($urandom));
   endtask

   task automatic queue_random_frame();
      logic [3:0]  op;
      logic [63:0] len;
      int          pick;
      int          form;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         op = wsd_pkg::OP_TEXT;
      end else if (pick < 85) begin
         op = wsd_pkg::OP_BINARY;
      end else begin
         op = 4'($urandom);
         while (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY ||
                op == wsd_pkg::OP_CLOSE) op = 4'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) len = 64'($urandom_range(0, 1));
      else if (pick < 75) len = 64'($urandom_range(2, 30));
      else if (pick < 92) len = 64'($urandom_range(31, 125));
      else len = 64'($urandom_range(126, 300));
      pick = $urandom_range(0, 9);
      if (len < 126) form = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
      else form = (pick < 7) ? 1 : 2;
      queue_frame(op, 1'($urandom), len, form, int'(len));
   endtask

   task automatic wait_idle();
      while (bytes_taken != bytes_queued || out_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_chunk_size(input logic [15:0] v);
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      chunk_cfg = v;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            deframe_byte(req_tdata);
         end
         if (req_tvalid && !req_tready) begin
            // hold the item
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (rx_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= rx_bytes.pop_front();
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      wsd_pkg::rsp_item_type seen;
      wsd_pkg::rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = '{kind: rsp_tuser[0], payload_byte: rsp_tdata, is_text: rsp_tuser[1],
                     chunk_last: rsp_tlast};
            if (out_due.size() == 0) begin
               flag_error($sformatf("unexpected item %p", seen));
            end else begin
               want = out_due.pop_front();
               if (seen.kind !== want.kind)
                  flag_error($sformatf("kind %b, want %b", seen.kind, want.kind));
               if (seen.payload_byte !== want.payload_byte)
                  flag_error($sformatf("payload_byte %h, want %h", seen.payload_byte,
                                       want.payload_byte));
               if (seen.is_text !== want.is_text)
                  flag_error($sformatf("is_text %b, want %b", seen.is_text, want.is_text));
               if (seen.chunk_last !== want.chunk_last)
                  flag_error($sformatf("chunk_last %b, want %b", seen.chunk_last,
                                       want.chunk_last));
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int          scene;
      int unsigned target;
      int unsigned n;
      chunk_cfg = wsd_pkg::MAX_CHUNK_RESET;
      ph = P_HDR1;
      frame_op = '0;
      masked = 1'b0;
      remaining = '0;
      field_left = '0;
      key = '0;
      key_pos = '0;
      chunk_cnt = '0;
      closed = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty frames, each length form, masked and plain, discarded opcodes
      queue_frame(wsd_pkg::OP_TEXT, 1'b0, 64'd0, 0, 0);
      queue_frame(wsd_pkg::OP_BINARY, 1'b1, 64'd0, 1, 0);
      queue_frame(wsd_pkg::OP_TEXT, 1'b1, 64'd3, 0, 3);
      queue_frame(wsd_pkg::OP_BINARY, 1'b0, 64'd2, 1, 2);
      queue_frame(wsd_pkg::OP_TEXT, 1'b1, 64'd1, 2, 1);
      queue_frame(4'h9, 1'b1, 64'd2, 0, 2);
      queue_frame(4'hA, 1'b0, 64'd0, 0, 0);
      queue_frame(4'h0, 1'b0, 64'd1, 0, 1);
      queue_frame(4'hF, 1'b0, 64'd1, 0, 1);
      wait_idle();

      // chunk size lowered in the middle of a chunk
      write_chunk_size(16'd3);
      queue_frame(wsd_pkg::OP_TEXT, 1'b1, 64'd8, 0, 2);
      wait_idle();
      write_chunk_size(16'd1);
      repeat (6) put_byte(8'($urandom));
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: write_chunk_size(16'd0);
            1: write_chunk_size(16'hFFFF);
            2: write_chunk_size(16'd1);
            3: write_chunk_size(16'd2);
            4: write_chunk_size(16'($urandom));
            default: write_chunk_size(16'($urandom_range(1, 24)));
         endcase
         calm = (p == 9);
         target = bytes_queued + 40;
         while (bytes_queued < target) queue_random_frame();
         wait_idle();
      end

      // closing frame variants, or a frame too long to ever finish
      write_chunk_size(16'($urandom_range(2, 8)));
      scene = $urandom_range(0, 3);
      n = $urandom_range(1, 20);
      case (scene)
         0: queue_frame(wsd_pkg::OP_CLOSE, 1'($urandom), 64'd0, $urandom_range(0, 2), 0);
         1: queue_frame(wsd_pkg::OP_CLOSE, 1'($urandom), 64'(n), 0, n);
         2: queue_frame(wsd_pkg::OP_CLOSE, 1'b1, 64'(n), 2, n);
         default: queue_frame($urandom_range(0, 1) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BINARY,
                              1'($urandom),
                              {8'($urandom_range(1, 255)), 56'($urandom)}, 2, 40);
      endcase
      repeat (16) put_byte(8'($urandom));

      wait_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0 && out_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #400us;
      $display("Some tests failed");
      $finish;
   end

endmodule
